// ===== hw/rtl/fcrm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcrm_pkg
// Shared types and constants of the falling column rain mask block: grid
// sizes, field widths, operation codes, register selects and word types.
// ----------------------------------------------------------------------------
package fcrm_pkg;

   localparam int MAX_COLUMNS = 64;
   localparam int MAX_ROWS    = 32;

   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int LEN_W       = ROW_W;
   localparam int HEAD_W      = ROW_W + 2;
   localparam int TAIL_W      = HEAD_W + 1;
   localparam int GADDR_W     = ROW_W + COL_W;
   localparam int GLYPH_DEPTH = MAX_ROWS * MAX_COLUMNS;

   localparam int GLYPH_W     = 16;
   localparam int COLS_REG_W  = 7;
   localparam int ROWS_REG_W  = 6;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [GLYPH_W-1:0] SPACE_CODE = 16'd32;

   localparam logic [COLS_REG_W-1:0] COLS_RESET = 7'd64;
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 6'd32;

   localparam logic CSR_REG_COLS = 1'b0;
   localparam logic CSR_REG_ROWS = 1'b1;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_LOAD = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic [5:0]         spawn_column;
      logic [4:0]         spawn_length;
      logic [4:0]         cell_row;
      logic [5:0]         cell_column;
      logic [GLYPH_W-1:0] glyph;
   } req_type;

   typedef struct packed {
      logic [GLYPH_W-1:0] cell_char;
      logic               cell_lit;
   } rsp_type;

   typedef struct packed {
      logic signed [HEAD_W-1:0] head;
      logic [LEN_W-1:0]         len;
      logic [MAX_ROWS-1:0]      lit;
   } col_word_type;

   typedef struct packed {
      logic accept_tick;
      logic accept_load;
      logic accept_read;
      logic walk_issue;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic walk_last;
   } sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_RESP
   } state_type;

endpackage

// ===== hw/rtl/fcrm_csr.sv =====
// ----------------------------------------------------------------------------
// fcrm_csr
// Configuration registers: column count and row count, written and read
// over the register port.
// ----------------------------------------------------------------------------
module fcrm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fcrm_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fcrm_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fcrm_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic [fcrm_pkg::COLS_REG_W-1:0]     cols_raw,
   output logic [fcrm_pkg::ROWS_REG_W-1:0]     rows_raw
);
   import fcrm_pkg::*;

   logic [COLS_REG_W-1:0] cols_ff;
   logic [ROWS_REG_W-1:0] rows_ff;
   logic                  wr_en;
   logic                  reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_sel = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            CSR_REG_COLS: cols_ff <= pwdata[COLS_REG_W-1:0];
            CSR_REG_ROWS: rows_ff <= pwdata[ROWS_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         CSR_REG_COLS: prdata = CSR_DATA_W'(cols_ff);
         CSR_REG_ROWS: prdata = CSR_DATA_W'(rows_ff);
         default:      prdata = '0;
      endcase
   end

   assign cols_raw = cols_ff;
   assign rows_raw = rows_ff;

endmodule

// ===== hw/rtl/fcrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcrm_ctrl
// Controller: takes commands, sequences the column walk of a frame tick and
// the cell read.
// ----------------------------------------------------------------------------
module fcrm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_op,
   input  fcrm_pkg::sts_type sts,
   output fcrm_pkg::cmd_type cmd,
   output logic              busy
);
   import fcrm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               case (req_op)
                  OP_TICK: begin
                     cmd.accept_tick = 1'b1;
                     state_in        = ST_WALK;
                  end
                  OP_LOAD: cmd.accept_load = 1'b1;
                  OP_READ: begin
                     cmd.accept_read = 1'b1;
                     state_in        = ST_RESP;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            cmd.walk_issue = 1'b1;
            if (sts.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_IDLE;
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== hw/rtl/fcrm_dp.sv =====
// ----------------------------------------------------------------------------
// fcrm_dp
// Datapath: per-column streak memory (head, length, lit rows) with one valid
// bit per column, glyph memory, and the column update stage.
// ----------------------------------------------------------------------------
module fcrm_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  fcrm_pkg::cmd_type               cmd,
   input  fcrm_pkg::req_type               req_data,
   input  logic [fcrm_pkg::COLS_REG_W-1:0] cols_raw,
   input  logic [fcrm_pkg::ROWS_REG_W-1:0] rows_raw,
   output fcrm_pkg::sts_type               sts,
   output logic                            rsp_valid,
   output fcrm_pkg::rsp_type               rsp_data
);
   import fcrm_pkg::*;

   col_word_type             col_mem [MAX_COLUMNS];
   logic [GLYPH_W-1:0]       glyph_mem [GLYPH_DEPTH];

   logic [MAX_COLUMNS-1:0]   col_valid_ff;
   col_word_type             col_rdata_ff;
   logic                     col_rvalid_ff;
   logic [GLYPH_W-1:0]       glyph_rdata_ff;

   logic [COL_W-1:0]         walk_idx_ff;
   logic                     wb_vld_ff;
   logic [COL_W-1:0]         wb_col_ff;
   logic [COL_W-1:0]         spawn_col_ff;
   logic [LEN_W-1:0]         spawn_len_ff;
   logic                     spawn_ok_ff;
   logic [ROW_W-1:0]         rd_row_ff;
   logic                     rd_inside_ff;

   logic [COLS_REG_W-1:0]    cols_eff;
   logic [ROWS_REG_W-1:0]    rows_eff;
   logic [ROWS_REG_W-1:0]    rows_m1;
   logic [LEN_W-1:0]         spawn_sat;
   logic                     in_grid;
   logic [GADDR_W-1:0]       gaddr;
   logic                     col_re;
   logic [COL_W-1:0]         col_raddr;

   logic [LEN_W-1:0]         len0;
   logic signed [HEAD_W-1:0] head0;
   logic [MAX_ROWS-1:0]      lit0;
   logic                     spawn_hit;
   logic [LEN_W-1:0]         len1;
   logic signed [HEAD_W-1:0] head1;
   logic signed [HEAD_W-1:0] head_nx;
   logic signed [TAIL_W-1:0] tail;
   logic signed [TAIL_W-1:0] rows_s;
   logic                     retire;
   logic [MAX_ROWS-1:0]      lit1;
   logic                     col_we;
   col_word_type             col_wdata;

   // clamp register values into the grid
   always_comb begin
      if (cols_raw == '0) begin
         cols_eff = COLS_REG_W'(1);
      end else if (cols_raw > COLS_REG_W'(MAX_COLUMNS)) begin
         cols_eff = COLS_REG_W'(MAX_COLUMNS);
      end else begin
         cols_eff = cols_raw;
      end
      if (rows_raw == '0) begin
         rows_eff = ROWS_REG_W'(1);
      end else if (rows_raw > ROWS_REG_W'(MAX_ROWS)) begin
         rows_eff = ROWS_REG_W'(MAX_ROWS);
      end else begin
         rows_eff = rows_raw;
      end
   end

   assign rows_m1   = rows_eff - ROWS_REG_W'(1);
   assign spawn_sat = (ROWS_REG_W'(req_data.spawn_length) > rows_m1) ?
                      rows_m1[LEN_W-1:0] : req_data.spawn_length;
   assign in_grid   = (ROWS_REG_W'(req_data.cell_row) < rows_eff) &&
                      (COLS_REG_W'(req_data.cell_column) < cols_eff);
   assign gaddr     = {req_data.cell_row, req_data.cell_column};
   assign col_re    = cmd.accept_read | cmd.walk_issue;
   assign col_raddr = cmd.accept_read ? req_data.cell_column : walk_idx_ff;

   assign sts.walk_last = (COLS_REG_W'(walk_idx_ff) == (cols_eff - COLS_REG_W'(1)));

   // walk control and request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_vld_ff   <= 1'b0;
         spawn_ok_ff <= 1'b0;
      end else begin
         wb_vld_ff <= cmd.walk_issue;
         if (cmd.accept_tick) begin
            spawn_ok_ff <= (COLS_REG_W'(req_data.spawn_column) < cols_eff) &&
                           (spawn_sat != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      wb_col_ff <= walk_idx_ff;
      if (cmd.accept_tick) begin
         walk_idx_ff  <= '0;
         spawn_col_ff <= req_data.spawn_column;
         spawn_len_ff <= spawn_sat;
      end else if (cmd.walk_issue) begin
         walk_idx_ff <= walk_idx_ff + COL_W'(1);
      end
      if (cmd.accept_read) begin
         rd_row_ff    <= req_data.cell_row;
         rd_inside_ff <= in_grid;
      end
   end

   // column memory
   always_ff @(posedge clock) begin
      if (col_re) begin
         col_rdata_ff <= col_mem[col_raddr];
      end
      if (col_we) begin
         col_mem[wb_col_ff] <= col_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff  <= '0;
         col_rvalid_ff <= 1'b0;
      end else begin
         if (col_re) begin
            col_rvalid_ff <= col_valid_ff[col_raddr];
         end
         if (col_we) begin
            col_valid_ff[wb_col_ff] <= 1'b1;
         end
      end
   end

   // glyph memory
   always_ff @(posedge clock) begin
      if (cmd.accept_load && in_grid) begin
         glyph_mem[gaddr] <= req_data.glyph;
      end
      if (cmd.accept_read) begin
         glyph_rdata_ff <= glyph_mem[gaddr];
      end
   end

   // column update: spawn, clear oldest cell, advance head, light new cell
   always_comb begin
      len0      = col_rvalid_ff ? col_rdata_ff.len  : '0;
      head0     = col_rvalid_ff ? col_rdata_ff.head : '0;
      lit0      = col_rvalid_ff ? col_rdata_ff.lit  : '0;
      spawn_hit = spawn_ok_ff && (wb_col_ff == spawn_col_ff) && (len0 == '0);
      len1      = spawn_hit ? spawn_len_ff : len0;
      head1     = spawn_hit ? -$signed(HEAD_W'(spawn_len_ff)) : head0;
      head_nx   = head1 + HEAD_W'(1);
      tail      = TAIL_W'(head1) + $signed(TAIL_W'(len1));
      rows_s    = $signed(TAIL_W'(rows_eff));
      retire    = TAIL_W'(head_nx) >= rows_s;
      lit1      = lit0;
      if (!head1[HEAD_W-1] && (head1 < HEAD_W'(MAX_ROWS))) begin
         lit1[head1[ROW_W-1:0]] = 1'b0;
      end
      if (!tail[TAIL_W-1] && (tail < rows_s)) begin
         lit1[tail[ROW_W-1:0]] = 1'b1;
      end
      col_we         = wb_vld_ff && (len1 != '0);
      col_wdata.head = retire ? '0 : head_nx;
      col_wdata.len  = retire ? '0 : len1;
      col_wdata.lit  = lit1;
   end

   // read result
   assign rsp_valid          = cmd.respond;
   assign rsp_data.cell_lit  = rd_inside_ff & col_rvalid_ff & col_rdata_ff.lit[rd_row_ff];
   assign rsp_data.cell_char = rsp_data.cell_lit ? glyph_rdata_ff : SPACE_CODE;

endmodule

// ===== hw/rtl/falling_column_rain_mask.sv =====
// ----------------------------------------------------------------------------
// falling_column_rain_mask
// Character grid with falling streaks: load glyph, frame tick, read cell.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Load glyph leaves
// busy low. Read cell raises busy for one cycle and drives its word on
// rsp_data with rsp_valid high in the cycle after acceptance; that word
// must be taken then, as it is not held. Frame tick walks the column memory
// one column per cycle over the clamped column count, then passes through a
// drain state that finishes the last column update. Lit state is cleared at
// reset through per-column valid bits, so no clearing pass is needed after
// reset.
module falling_column_rain_mask (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  fcrm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output fcrm_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fcrm_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [fcrm_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [fcrm_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);
   import fcrm_pkg::*;

   logic [COLS_REG_W-1:0] cols_raw;
   logic [ROWS_REG_W-1:0] rows_raw;
   cmd_type               cmd;
   sts_type               sts;

   fcrm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .cols_raw (cols_raw),
      .rows_raw (rows_raw)
   );

   fcrm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_data.op),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   fcrm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .cols_raw  (cols_raw),
      .rows_raw  (rows_raw),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_read_responds: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.op == OP_READ) |=> rsp_valid)
      else $error("read cell gave no result word");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.op == OP_TICK) |=> busy && !rsp_valid)
      else $error("frame tick did not hold busy");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result word repeated");

   a_dark_space: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.cell_lit |-> rsp_data.cell_char == SPACE_CODE)
      else $error("dark cell returned a glyph");

endmodule

// ===== tb/sv/falling_column_rain_mask_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// falling_column_rain_mask_test
// Self-checking bench for the falling column rain mask grid. A queue of
// command words feeds a clocked driver, and a shadow grid predicts every read
// as each word is accepted. The run covers several grid sizes set over the
// register port, including clamped extremes, with random sender gaps.
// ----------------------------------------------------------------------------
module falling_column_rain_mask_test;
   import fcrm_pkg::*;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         STALL_LIMIT = 4000;
   localparam int         SETTLE      = MAX_COLUMNS + 6;
   localparam int         PHASES      = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   falling_column_rain_mask DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // shadow grid
   logic [COLS_REG_W-1:0] cols_reg = COLS_RESET;
   logic [ROWS_REG_W-1:0] rows_reg = ROWS_RESET;
   int                    streak_head [MAX_COLUMNS];
   int                    streak_len  [MAX_COLUMNS];
   bit                    lit_grid    [MAX_ROWS][MAX_COLUMNS];
   logic [GLYPH_W-1:0]    glyph_grid  [MAX_ROWS][MAX_COLUMNS];

   req_type pending_words [$];
   rsp_type expected_cells [$];

   int  accepted_words = 0;
   int  n_ticks = 0;
   int  n_loads = 0;
   int  n_reads = 0;
   int  n_lit_reads = 0;
   int  n_unused = 0;
   int  mismatches = 0;
   int  stall_cycles = 0;
   bit  drain_hold = 1'b0;

   // stimulus-side view of the grid
   int         gen_cols = MAX_COLUMNS;
   int         gen_rows = MAX_ROWS;
   bit         painted_cell [MAX_ROWS][MAX_COLUMNS];
   logic [10:0] painted_spots [$];

   function automatic int clamp_span(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void mark_cell(int row, int col, bit v);
      if (row >= 0 && row < MAX_ROWS && col < MAX_COLUMNS) lit_grid[row][col] = v;
   endfunction

   function automatic void advance_frame(logic [5:0] spawn_col, logic [4:0] spawn_len);
      int cols;
      int rows;
      int span;
      int tail;
      cols = clamp_span(cols_reg, MAX_COLUMNS);
      rows = clamp_span(rows_reg, MAX_ROWS);
      if (spawn_col < cols && streak_len[spawn_col] == 0) begin
         span = spawn_len;
         if (span > rows - 1) span = rows - 1;
         streak_head[spawn_col] = -span;
         streak_len[spawn_col]  = span;
      end
      for (int c = 0; c < cols; c++) begin
         if (streak_len[c] != 0) begin
            mark_cell(streak_head[c], c, 1'b0);
            streak_head[c] += 1;
            tail = streak_head[c] + streak_len[c] - 1;
            if (tail < rows) mark_cell(tail, c, 1'b1);
            if (streak_head[c] >= rows) begin
               streak_head[c] = 0;
               streak_len[c]  = 0;
            end
         end
      end
   endfunction

   function automatic void apply_word(req_type w);
      bit      in_grid;
      rsp_type cell_word;
      in_grid = w.cell_row < clamp_span(rows_reg, MAX_ROWS)
                && w.cell_column < clamp_span(cols_reg, MAX_COLUMNS);
      case (w.op)
         OP_TICK: begin
            n_ticks++;
            advance_frame(w.spawn_column, w.spawn_length);
         end
         OP_LOAD: begin
            n_loads++;
            if (in_grid) glyph_grid[w.cell_row][w.cell_column] = w.glyph;
         end
         OP_READ: begin
            n_reads++;
            if (in_grid && lit_grid[w.cell_row][w.cell_column]) begin
               cell_word.cell_char = glyph_grid[w.cell_row][w.cell_column];
               cell_word.cell_lit  = 1'b1;
               n_lit_reads++;
            end else begin
               cell_word.cell_char = SPACE_CODE;
               cell_word.cell_lit  = 1'b0;
            end
            expected_cells.push_back(cell_word);
            if (n_reads % 17 == 0) drain_hold = 1'b1;
         end
         default: begin
            n_unused++;
         end
      endcase
   endfunction

   // driver
   always @(posedge clock) begin : word_driver
      logic go;
      int   idle_pct;
      if (reset) begin
         start <= 1'b0;
      end else begin
         go = start;
         if (start && !busy) begin
            apply_word(pending_words.pop_front());
            accepted_words++;
            go = 1'b0;
         end
         if (drain_hold && expected_cells.size() == 0) drain_hold = 1'b0;
         idle_pct = (accepted_words < 190) ? 34 : (accepted_words < 380) ? 63 : 0;
         if (!go && !drain_hold && pending_words.size() > 0
             && $urandom_range(0, 99) >= idle_pct) go = 1'b1;
         start <= go;
         if (go) req_data <= pending_words[0];
      end
   end

   // monitor
   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_cells.size() == 0) begin
            $display("%0t unexpected result: expected none, got char %h lit %b",
                     $time, rsp_data.cell_char, rsp_data.cell_lit);
            mismatches++;
         end else begin
            want = expected_cells.pop_front();
            if (rsp_data.cell_char !== want.cell_char) begin
               $display("%0t cell_char mismatch: expected %h, got %h",
                        $time, want.cell_char, rsp_data.cell_char);
               mismatches++;
            end
            if (rsp_data.cell_lit !== want.cell_lit) begin
               $display("%0t cell_lit mismatch: expected %b, got %b",
                        $time, want.cell_lit, rsp_data.cell_lit);
               mismatches++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic void queue_word(logic [1:0] op, logic [5:0] scol, logic [4:0] slen,
                                      logic [4:0] row, logic [5:0] col, logic [15:0] g);
      req_type w;
      bit      in_grid;
      in_grid = row < gen_rows && col < gen_cols;
      if (op == OP_READ && in_grid && !painted_cell[row][col]) op = OP_LOAD;
      if (op == OP_LOAD && in_grid && !painted_cell[row][col]) begin
         painted_cell[row][col] = 1'b1;
         painted_spots.push_back({row, col});
      end
      w.op           = op;
      w.spawn_column = scol;
      w.spawn_length = slen;
      w.cell_row     = row;
      w.cell_column  = col;
      w.glyph        = g;
      pending_words.push_back(w);
   endfunction

   function automatic void queue_random_word();
      int          r;
      logic [1:0]  op;
      logic [5:0]  scol;
      logic [4:0]  row;
      logic [5:0]  col;
      logic [10:0] spot;
      r    = $urandom_range(0, 99);
      scol = 6'($urandom);
      row  = 5'($urandom);
      col  = 6'($urandom);
      if (r < 35) begin
         op = OP_TICK;
         if ($urandom_range(0, 4) != 0) scol = 6'($urandom_range(0, gen_cols - 1));
      end else if (r < 62) begin
         op = OP_LOAD;
         if ($urandom_range(0, 9) != 0) begin
            row = 5'($urandom_range(0, gen_rows - 1));
            col = 6'($urandom_range(0, gen_cols - 1));
         end
      end else if (r < 95) begin
         op = OP_READ;
         if (painted_spots.size() > 0 && $urandom_range(0, 7) != 0) begin
            spot = painted_spots[$urandom_range(0, painted_spots.size() - 1)];
            row  = spot[10:6];
            col  = spot[5:0];
         end
      end else begin
         op = OP_UNUSED;
      end
      queue_word(op, scol, 5'($urandom), row, col, 16'($urandom));
   endfunction

   task automatic wait_idle();
      while (pending_words.size() != 0 || expected_cells.size() != 0 || start)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_size(logic idx, int value);
      logic [CSR_DATA_W-1:0] want_reg;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (idx == CSR_REG_COLS) begin
         cols_reg = value[COLS_REG_W-1:0];
         gen_cols = clamp_span(cols_reg, MAX_COLUMNS);
         want_reg = CSR_DATA_W'(value[COLS_REG_W-1:0]);
      end else begin
         rows_reg = value[ROWS_REG_W-1:0];
         gen_rows = clamp_span(rows_reg, MAX_ROWS);
         want_reg = CSR_DATA_W'(value[ROWS_REG_W-1:0]);
      end
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== want_reg) begin
         $display("%0t register %0d readback: expected %h, got %h",
                  $time, idx, want_reg, prdata);
         mismatches++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   int phase_cols  [PHASES] = '{8, 1, 127, 3, 0, 16, 64, 5};
   int phase_rows  [PHASES] = '{8, 1, 63, 2, 0, 12, 32, 31};
   int phase_words [PHASES] = '{110, 30, 80, 60, 25, 110, 60, 55};

   initial begin : stimulus
      foreach (streak_len[c]) begin
         streak_len[c]  = 0;
         streak_head[c] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // full-size grid: field extremes, idle and busy columns
      queue_word(OP_LOAD, 6'd0, 5'd0, 5'd0, 6'd0, 16'h0000);
      queue_word(OP_LOAD, 6'd0, 5'd0, 5'd31, 6'd63, 16'hFFFF);
      queue_word(OP_LOAD, 6'd0, 5'd0, 5'd0, 6'd2, 16'h5A5A);
      queue_word(OP_LOAD, 6'd0, 5'd0, 5'd1, 6'd2, 16'hA5A5);
      queue_word(OP_READ, 6'd0, 5'd0, 5'd0, 6'd0, 16'h0000);
      queue_word(OP_TICK, 6'd2, 5'd0, 5'd0, 6'd0, 16'h0000);
      queue_word(OP_TICK, 6'd2, 5'd2, 5'd0, 6'd0, 16'h0000);
      queue_word(OP_TICK, 6'd63, 5'd31, 5'd0, 6'd0, 16'h0000);
      queue_word(OP_TICK, 6'd2, 5'd5, 5'd0, 6'd0, 16'h0000);
      queue_word(OP_READ, 6'd0, 5'd0, 5'd0, 6'd2, 16'h0000);
      queue_word(OP_READ, 6'd0, 5'd0, 5'd1, 6'd2, 16'h0000);
      queue_word(OP_READ, 6'd0, 5'd0, 5'd31, 6'd63, 16'h0000);
      queue_word(OP_UNUSED, 6'd63, 5'd31, 5'd31, 6'd63, 16'hFFFF);

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         write_size(CSR_REG_COLS, phase_cols[p]);
         write_size(CSR_REG_ROWS, phase_rows[p]);
         if (p == 0) begin
            // shrunken grid: out-of-range starts and cells, length saturation
            queue_word(OP_TICK, 6'd9, 5'd3, 5'd0, 6'd0, 16'h0000);
            queue_word(OP_TICK, 6'd7, 5'd31, 5'd0, 6'd0, 16'h0000);
            queue_word(OP_LOAD, 6'd0, 5'd0, 5'd10, 6'd3, 16'h1234);
            queue_word(OP_READ, 6'd0, 5'd0, 5'd10, 6'd3, 16'h0000);
            queue_word(OP_READ, 6'd0, 5'd0, 5'd2, 6'd40, 16'h0000);
            queue_word(OP_LOAD, 6'd0, 5'd0, 5'd0, 6'd7, 16'hBEEF);
            queue_word(OP_TICK, 6'd0, 5'd0, 5'd0, 6'd0, 16'h0000);
            queue_word(OP_READ, 6'd0, 5'd0, 5'd0, 6'd7, 16'h0000);
         end
         repeat (phase_words[p]) queue_random_word();
      end
      wait_idle();

      $display("Covered %0d words over %0d grid sizes: %0d ticks, %0d loads, %0d unused",
               accepted_words, PHASES + 1, n_ticks, n_loads, n_unused);
      $display("Checked %0d reads, %0d of them on lit cells", n_reads, n_lit_reads);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/fcrm_pkg.sv
hw/rtl/fcrm_csr.sv
hw/rtl/fcrm_ctrl.sv
hw/rtl/fcrm_dp.sv
hw/rtl/falling_column_rain_mask.sv
tb/sv/falling_column_rain_mask_test.sv
